// ----- rtl/core/wtnp_pkg.sv -----
package wtnp_pkg;

    localparam logic [7:0] CH_PLUS     = 8'd43;
    localparam logic [7:0] CH_MINUS    = 8'd45;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] DELIM_RESET = 8'h20;
    localparam int         MAG_W       = 34;
    localparam int         VALUE_W     = 32;
    localparam int         LEN_W       = 6;

    typedef enum logic [1:0] {
        KIND_NUMBER   = 2'd0,
        KIND_WORD     = 2'd1,
        KIND_TOO_LONG = 2'd2
    } kind_t;

    // classified byte, as handed from front to back
    typedef struct packed {
        logic       is_delim;
        logic       is_digit;
        logic       is_plus;
        logic       is_minus;
        logic [3:0] digit;
    } token_t;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic [LEN_W-1:0]     length;
        logic                 range_err;
    } result_t;

endpackage

// ----- rtl/core/wtnp_fifo.sv -----
module wtnp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");

endmodule

// ----- rtl/core/wtnp_front.sv -----
module wtnp_front import wtnp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       delimiter_we,
    input  logic [7:0] delimiter_char,
    input  logic [7:0] data_byte,
    output token_t     tok
);

    logic [7:0] delim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (delimiter_we)
        begin
            delim_reg <= delimiter_char;
        end
    end

    logic [7:0] diff;

    assign diff         = data_byte - CH_ZERO;
    assign tok.is_delim = (data_byte == delim_reg);
    assign tok.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign tok.is_plus  = (data_byte == CH_PLUS);
    assign tok.is_minus = (data_byte == CH_MINUS);
    assign tok.digit    = diff[3:0];

endmodule

// ----- rtl/core/wtnp_back.sv -----
module wtnp_back import wtnp_pkg::*; #(
    parameter int MAX_WORD_CHARS   = 64,
    parameter int MAX_NUMBER_CHARS = 10
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_empty,
    input  token_t  tok,
    output logic    tok_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    localparam int CW    = $clog2(MAX_WORD_CHARS + 1);
    localparam int CMP_W = (CW > 4) ? CW : 4;

    logic [CW-1:0]    count_reg, count_next;
    logic             first_digit_reg, first_digit_next;
    logic             first_plus_reg, first_plus_next;
    logic             first_minus_reg, first_minus_next;
    logic             rest_digits_reg, rest_digits_next;
    logic [MAG_W-1:0] mag_reg, mag_next;

    logic [CMP_W-1:0]   count_cmp;
    logic               buf_full, sign, is_num;
    logic [VALUE_W-1:0] neg_value;

    assign tok_pop   = !tok_empty && !res_full;
    assign count_cmp = CMP_W'(count_reg);
    assign buf_full  = (count_reg >= CW'(MAX_WORD_CHARS));
    assign sign      = first_plus_reg || first_minus_reg;
    assign is_num    = (count_cmp <= CMP_W'(MAX_NUMBER_CHARS))
                       && (first_digit_reg || sign)
                       && !((count_reg == CW'(1)) && sign)
                       && rest_digits_reg;
    assign neg_value = '0 - mag_reg[VALUE_W-1:0];

    always_comb
    begin
        count_next       = count_reg;
        first_digit_next = first_digit_reg;
        first_plus_next  = first_plus_reg;
        first_minus_next = first_minus_reg;
        rest_digits_next = rest_digits_reg;
        mag_next         = mag_reg;
        res_push         = 1'b0;
        res.kind         = KIND_TOO_LONG;
        res.value        = '0;
        res.length       = '0;
        res.range_err    = 1'b0;

        if (tok_pop)
        begin
            if (buf_full || tok.is_delim)
            begin
                // full buffer drops the byte, even a delimiter
                count_next       = '0;
                first_digit_next = 1'b0;
                first_plus_next  = 1'b0;
                first_minus_next = 1'b0;
                rest_digits_next = 1'b1;
                mag_next         = '0;
                if (buf_full)
                begin
                    res_push = 1'b1;
                end
                else if (count_reg != '0)
                begin
                    res_push   = 1'b1;
                    res.length = LEN_W'(count_reg);
                    if (is_num)
                    begin
                        res.kind = KIND_NUMBER;
                        if (first_minus_reg)
                        begin
                            res.value     = neg_value;
                            res.range_err = (mag_reg > MAG_W'(64'd2147483648));
                        end
                        else
                        begin
                            res.value     = mag_reg[VALUE_W-1:0];
                            res.range_err = (mag_reg > MAG_W'(64'd2147483647));
                        end
                    end
                    else
                    begin
                        res.kind = KIND_WORD;
                    end
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    first_digit_next = tok.is_digit;
                    first_plus_next  = tok.is_plus;
                    first_minus_next = tok.is_minus;
                    mag_next = tok.is_digit ? MAG_W'(tok.digit) : '0;
                end
                else if (!tok.is_digit)
                begin
                    rest_digits_next = 1'b0;
                end
                else if (count_cmp < CMP_W'(MAX_NUMBER_CHARS))
                begin
                    // times ten as shift-add
                    mag_next = (mag_reg << 3) + (mag_reg << 1) + MAG_W'(tok.digit);
                end
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            first_digit_reg <= 1'b0;
            first_plus_reg  <= 1'b0;
            first_minus_reg <= 1'b0;
            rest_digits_reg <= 1'b1;
            mag_reg         <= '0;
        end
        else
        begin
            count_reg       <= count_next;
            first_digit_reg <= first_digit_next;
            first_plus_reg  <= first_plus_next;
            first_minus_reg <= first_minus_next;
            rest_digits_reg <= rest_digits_next;
            mag_reg         <= mag_next;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (tok_pop && !res_full))
        else $error("result pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WORD_CHARS))
        else $error("word count above buffer size");

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.kind == KIND_TOO_LONG)) |=> (count_reg == '0))
        else $error("too-long word not cleared");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.kind != KIND_NUMBER))
            |-> ((res.value == '0) && !res.range_err))
        else $error("non-number word carries a value");

endmodule

// ----- rtl/core/word_tokenizer_number_parser.sv -----
// Splits a byte stream into words at a programmable delimiter and parses
// signed decimal numbers.
// Input side is a queue write port: a byte is taken on a clock edge with
// push high and full low. Result side is a queue read port: while empty is
// low the oldest word is on word_kind/number_value/word_length/range_error,
// and pop with empty low takes it.
// delimiter_we loads delimiter_char into the delimiter register; write it
// only while no word is in flight.
// Throughput: one byte per cycle while full is low. The front classifies a
// byte in its accept cycle into a two-entry token queue; the back pops one
// token per cycle while the result queue has room and updates the word
// state with one shift-add for the times-ten step. A delimiter's result
// goes through the token queue and the back into the result queue.
// When the reader stalls, two results wait in the result queue, then the
// back stops, the token queue fills and full rises.
// Reset clears both queues and the word state; the delimiter returns to space.
module word_tokenizer_number_parser import wtnp_pkg::*; #(
    parameter int MAX_WORD_CHARS   = 64,
    parameter int MAX_NUMBER_CHARS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      delimiter_we,
    input  logic [7:0]                delimiter_char,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                data_byte,
    input  logic                      pop,
    output logic                      empty,
    output logic [1:0]                word_kind,
    output logic signed [VALUE_W-1:0] number_value,
    output logic [LEN_W-1:0]          word_length,
    output logic                      range_error
);

    localparam int TOK_W = $bits(token_t);
    localparam int RES_W = $bits(result_t);

    token_t             front_tok, back_tok;
    logic [TOK_W-1:0]   tok_rd_data;
    logic               tok_empty, tok_pop;
    result_t            back_res, out_res;
    logic [RES_W-1:0]   res_rd_data;
    logic               res_full, res_push;

    wtnp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .delimiter_we   (delimiter_we),
        .delimiter_char (delimiter_char),
        .data_byte      (data_byte),
        .tok            (front_tok)
    );

    wtnp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (2)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_tok),
        .full    (full),
        .rd_en   (tok_pop),
        .rd_data (tok_rd_data),
        .empty   (tok_empty)
    );

    assign back_tok = token_t'(tok_rd_data);

    wtnp_back #(
        .MAX_WORD_CHARS   (MAX_WORD_CHARS),
        .MAX_NUMBER_CHARS (MAX_NUMBER_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_empty (tok_empty),
        .tok       (back_tok),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    wtnp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign out_res      = result_t'(res_rd_data);
    assign word_kind    = out_res.kind;
    assign number_value = $signed(out_res.value);
    assign word_length  = out_res.length;
    assign range_error  = out_res.range_err;

endmodule

// ----- test/word_tokenizer_number_parser_tb.sv -----
module word_tokenizer_number_parser_tb;
    import wtnp_pkg::*;

    localparam int MAX_WORD = 64;
    localparam int MAX_NUM  = 10;
    localparam int LIMIT    = 200000;
    localparam int HOLD_LEN = 300;

    logic                      clk;
    logic                      rst_n;
    logic                      delimiter_we;
    logic [7:0]                delimiter_char;
    logic                      push;
    logic                      full;
    logic [7:0]                data_byte;
    logic                      pop;
    logic                      empty;
    logic [1:0]                word_kind;
    logic signed [VALUE_W-1:0] number_value;
    logic [LEN_W-1:0]          word_length;
    logic                      range_error;

    word_tokenizer_number_parser #(
        .MAX_WORD_CHARS   (MAX_WORD),
        .MAX_NUMBER_CHARS (MAX_NUM)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .delimiter_we   (delimiter_we),
        .delimiter_char (delimiter_char),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .pop            (pop),
        .empty          (empty),
        .word_kind      (word_kind),
        .number_value   (number_value),
        .word_length    (word_length),
        .range_error    (range_error)
    );

    typedef struct {
        string      txt;
        logic [7:0] fill;
        int         nfill;
        bit         typed;
        result_t    res;
    } word_row_t;

    // directed words, each followed by the current delimiter
    word_row_t dir_rows [0:18] = '{
        '{"0",           8'h00, 0,  1'b1, '{KIND_NUMBER,   32'd0,        6'd1,  1'b0}},
        '{"+",           8'h00, 0,  1'b1, '{KIND_WORD,     32'd0,        6'd1,  1'b0}},
        '{"-",           8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"+7",          8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"-0",          8'h00, 0,  1'b1, '{KIND_NUMBER,   32'd0,        6'd2,  1'b0}},
        '{"2147483647",  8'h00, 0,  1'b1, '{KIND_NUMBER,   32'h7fffffff, 6'd10, 1'b0}},
        '{"2147483648",  8'h00, 0,  1'b1, '{KIND_NUMBER,   32'h80000000, 6'd10, 1'b1}},
        '{"-2147483648", 8'h00, 0,  1'b1, '{KIND_WORD,     32'd0,        6'd11, 1'b0}},
        '{"-999999999",  8'h00, 0,  1'b1, '{KIND_NUMBER,   32'hc4653601, 6'd10, 1'b0}},
        '{"9999999999",  8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"4294967296",  8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"12a",         8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"a12",         8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"",            8'h00, 0,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"",            8'h00, 3,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"5",           8'hff, 2,  1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}},
        '{"",            8'h78, 63, 1'b1, '{KIND_WORD,     32'd0,        6'd63, 1'b0}},
        '{"",            8'h37, 64, 1'b1, '{KIND_TOO_LONG, 32'd0,        6'd0,  1'b0}},
        '{"-",           8'h39, 11, 1'b0, '{KIND_WORD,     32'd0,        6'd0,  1'b0}}
    };

    string edge_nums [0:3] = '{"2147483647", "2147483648", "4294967295", "4294967296"};

    // parser copy
    logic [7:0]       cur_delim;
    int               wd_count;
    logic [7:0]       wd_first;
    logic             wd_rest;
    logic [MAG_W-1:0] wd_mag;

    result_t pending_words [$];
    result_t head_word;
    result_t typed_res;
    bit      use_typed;
    int      err_count;
    int      cycles;
    int      burst_left;
    int      bytes_sent;
    bit      hold_req;
    int      hold_left;
    int      rx_mode;
    int      rx_mode_left;
    int      rx_tick;

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_word();
        wd_count = 0;
        wd_first = 8'd0;
        wd_rest  = 1'b1;
        wd_mag   = '0;
    endfunction

    // returns 1 when the byte finishes a word
    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        logic sgn;
        logic numeric;
        logic neg;
        r = '0;
        if (wd_count >= MAX_WORD)
        begin
            clear_word();
            r.kind = KIND_TOO_LONG;
            return 1'b1;
        end
        if (b == cur_delim)
        begin
            if (wd_count == 0)
                return 1'b0;
            sgn = (wd_first == CH_PLUS) || (wd_first == CH_MINUS);
            numeric = (wd_count <= MAX_NUM) && (is_dec(wd_first) || sgn)
                      && !(wd_count == 1 && sgn) && wd_rest;
            r.length = LEN_W'(wd_count);
            if (numeric)
            begin
                neg = (wd_first == CH_MINUS);
                r.kind = KIND_NUMBER;
                if (neg)
                begin
                    r.value     = 32'd0 - wd_mag[31:0];
                    r.range_err = wd_mag > 34'd2147483648;
                end
                else
                begin
                    r.value     = wd_mag[31:0];
                    r.range_err = wd_mag > 34'd2147483647;
                end
            end
            else
                r.kind = KIND_WORD;
            clear_word();
            return 1'b1;
        end
        if (wd_count == 0)
        begin
            wd_first = b;
            wd_mag   = is_dec(b) ? MAG_W'(b - CH_ZERO) : '0;
        end
        else if (!is_dec(b))
            wd_rest = 1'b0;
        else if (wd_count < MAX_NUM)
            wd_mag = wd_mag * 34'd10 + MAG_W'(b - CH_ZERO);
        wd_count++;
        return 1'b0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("word_tokenizer_number_parser_tb: FAIL");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: kind %0d length %0d", word_kind, word_length);
                err_count++;
            end
            else
            begin
                head_word = pending_words.pop_front();
                if (word_kind !== head_word.kind)
                begin
                    $error("word_kind: expected %0d, got %0d", head_word.kind, word_kind);
                    err_count++;
                end
                if (number_value !== head_word.value)
                begin
                    $error("number_value: expected %0d, got %0d",
                           $signed(head_word.value), number_value);
                    err_count++;
                end
                if (word_length !== head_word.length)
                begin
                    $error("word_length: expected %0d, got %0d",
                           head_word.length, word_length);
                    err_count++;
                end
                if (range_error !== head_word.range_err)
                begin
                    $error("range_error: expected %0d, got %0d",
                           head_word.range_err, range_error);
                    err_count++;
                end
            end
        end
    end

    // reader: switches among four random stall patterns, long hold on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_req)
            begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (!rst_n)
                pop <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(8, 80);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= rx_tick[2];
                endcase
            end
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_byte(input logic [7:0] b);
        result_t r;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push      <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
        if (parse_byte(b, r))
        begin
            if (use_typed)
                r = typed_res;
            pending_words.push_back(r);
        end
        @(negedge clk);
    endtask

    task automatic set_delim(input logic [7:0] v);
        push <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        // bytes that end no word may still be in the pipe
        repeat (6) @(negedge clk);
        delimiter_we   <= 1'b1;
        delimiter_char <= v;
        @(negedge clk);
        delimiter_we <= 1'b0;
        cur_delim  = v;
        burst_left = 0;
    endtask

    task automatic send_random_word();
        int sel;
        int n;
        int i;
        string s;
        sel = $urandom_range(0, 99);
        if (sel < 6)
        begin
            s = edge_nums[$urandom_range(0, 3)];
            if ($urandom_range(0, 1))
                send_byte(CH_MINUS);
            for (i = 0; i < s.len(); i++)
                send_byte(s[i]);
        end
        else if (sel < 45)
        begin
            case ($urandom_range(0, 2))
                1: send_byte(CH_PLUS);
                2: send_byte(CH_MINUS);
                default: ;
            endcase
            n = ($urandom_range(0, 2) == 0) ? MAX_NUM : $urandom_range(1, MAX_NUM + 1);
            for (i = 0; i < n; i++)
            begin
                if (i == 0 && n == MAX_NUM)
                    send_byte(CH_ZERO + 8'($urandom_range(1, 4)));
                else
                    send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        else if (sel < 65)
        begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(33, 126)));
        end
        else if (sel < 75)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                return;
        end
        else if (sel < 80)
        begin
            n = $urandom_range(60, 70);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(97, 122)));
        end
        else if (sel >= 85)
        begin
            // malformed number: minus or digit lead, a stray non-digit, or a lone minus or digit
            n = $urandom_range(0, 5);
            send_byte(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_ZERO + 8'd3);
            for (i = 0; i < n; i++)
                send_byte((i == n / 2) ? 8'($urandom_range(58, 126))
                                       : CH_ZERO + 8'($urandom_range(0, 9)));
        end
        send_byte(cur_delim);
    endtask

    initial
    begin
        int r;
        int j;
        int p;
        int start;
        logic [7:0] phase_delims [0:5];

        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = 8'd0;
        delimiter_we   = 1'b0;
        delimiter_char = 8'd0;
        use_typed      = 1'b0;
        hold_req       = 1'b0;
        cur_delim      = DELIM_RESET;
        clear_word();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words under the reset delimiter
        for (r = 0; r < $size(dir_rows); r++)
        begin
            for (j = 0; j < dir_rows[r].txt.len(); j++)
                send_byte(dir_rows[r].txt[j]);
            for (j = 0; j < dir_rows[r].nfill; j++)
                send_byte(dir_rows[r].fill);
            typed_res = dir_rows[r].res;
            use_typed = dir_rows[r].typed;
            send_byte(cur_delim);
            use_typed = 1'b0;
        end

        phase_delims[0] = 8'h00;
        phase_delims[1] = 8'hff;
        phase_delims[2] = CH_ZERO + 8'd5;
        phase_delims[3] = CH_MINUS;
        phase_delims[4] = 8'($urandom_range(0, 255));
        phase_delims[5] = 8'($urandom_range(0, 255));

        for (p = 0; p < 6; p++)
        begin
            set_delim(phase_delims[p]);
            // reader backs off for a long stretch so the block fills and stalls input
            if (p == 0)
                hold_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < 95)
                send_random_word();
        end

        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("word_tokenizer_number_parser_tb: PASS");
        else
            $display("word_tokenizer_number_parser_tb: FAIL");
        $finish;
    end

endmodule
